### rtl/core/rsi_pkg.sv
package rsi_pkg;

	localparam int RSI_FRAC_BITS  = 16;
	localparam int RSI_IN_DATA_W  = 320;
	localparam int RSI_OUT_DATA_W = 128;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return m;
	endfunction

	// Shift right towards zero rather than towards minus infinity.
	function automatic logic signed [63:0] drop_frac(input logic signed [63:0] v,
		input int unsigned f);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = m >> f;
		return v[63] ? -signed'(m) : signed'(m);
	endfunction

endpackage

### rtl/core/rsi_isqrt.sv
module rsi_isqrt import rsi_pkg::*; #(
	parameter int IN_W   = 64,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [IN_W-1:0]     in_val,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_vld,
	output logic [IN_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int N = IN_W / 2;

	logic              vld_s  [N+1];
	logic [IN_W-1:0]   rem_s  [N+1];
	logic [IN_W-1:0]   root_s [N+1];
	logic [SIDE_W-1:0] side_s [N+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_val;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	// One result bit per stage, working down from the top pair of input bits.
	for (genvar g = 0; g < N; g++) begin : g_step
		localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * g);
		logic [IN_W-1:0] trial;
		logic [IN_W-1:0] rem_nx;
		logic [IN_W-1:0] root_nx;

		always_comb begin
			trial = root_s[g] + BIT;
			if (rem_s[g] >= trial) begin
				rem_nx  = rem_s[g] - trial;
				root_nx = (root_s[g] >> 1) + BIT;
			end else begin
				rem_nx  = rem_s[g];
				root_nx = root_s[g] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= rem_nx;
				root_s[g+1] <= root_nx;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N][N-1:0];
	assign out_side = side_s[N];

endmodule

### rtl/core/rsi_div.sv
module rsi_div import rsi_pkg::*; #(
	parameter int FRAC_BITS = RSI_FRAC_BITS,
	parameter int SIDE_W    = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [31:0]          num [3],
	input  logic [31:0]          den,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_vld,
	output logic [FRAC_BITS:0]   quo [3],
	output logic [SIDE_W-1:0]    out_side
);

	localparam int N = FRAC_BITS + 1;

	logic              vld_s  [N+1];
	logic [31:0]       den_s  [N+1];
	logic [32:0]       rem_s  [N+1][3];
	logic [N-1:0]      quo_s  [N+1][3];
	logic [SIDE_W-1:0] side_s [N+1];

	assign vld_s[0]  = in_vld;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;

	// The numerator never exceeds the divisor, so the quotient fits in N bits
	// and the remainder starts as the numerator itself.
	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_s[0][l] = {1'b0, num[l]};
		assign quo_s[0][l] = '0;
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		logic [32:0]  rem_nx [3];
		logic [N-1:0] quo_nx [3];

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_s[g][l] >= {1'b0, den_s[g]}) begin
					rem_nx[l] = {rem_s[g][l][31:0] - den_s[g], 1'b0};
					quo_nx[l] = {quo_s[g][l][N-2:0], 1'b1};
				end else begin
					rem_nx[l] = {rem_s[g][l][31:0], 1'b0};
					quo_nx[l] = {quo_s[g][l][N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
				for (int l = 0; l < 3; l++) begin
					rem_s[g+1][l] <= rem_nx[l];
					quo_s[g+1][l] <= quo_nx[l];
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign quo[l] = quo_s[N][l];
	end

	assign out_vld  = vld_s[N];
	assign out_side = side_s[N];

endmodule

### rtl/core/ray_sphere_intersect.sv
// Ray and sphere intersection on signed fixed-point coordinates.
// The slave channel takes one ray and one sphere per item; the master channel
// returns one result per item in the same order, with the hit flag in tuser.
// The direction is normalised by a pipelined square root and a three-lane
// divider, and the discriminant root comes from a second pipelined square
// root, each delivering one result bit per stage.
// From acceptance to m_tvalid the pipeline has three input stages, 32 root
// stages, FRAC_BITS + 1 divide stages, five stages for the dot product and
// discriminant, 32 more root stages and three stages for the distance and
// point. Throughput is one item per cycle unless a stalled result holds the
// pipeline; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline and s_tready
// hold until m_tready rises, so no item is dropped or repeated.
// Reset clears all valid bits; the block accepts items as soon as reset is
// released.
module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int FRAC_BITS = RSI_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
	// center_x, center_y, center_z, radius, one zero pad bit
	input  logic [RSI_IN_DATA_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// distance, point_x, point_y, point_z
	output logic [RSI_OUT_DATA_W-1:0] m_tdata,
	// hit
	output logic                      m_tuser
);

	localparam int QW     = FRAC_BITS + 1;
	localparam int UW     = FRAC_BITS + 2;
	localparam int SIDE1W = 96 * 3 + 64 + 31;
	localparam int SIDE2W = 96 + 3 + 96 + 64 + 31 + 1;
	localparam int SIDE3W = 96 + 3 * UW + 32 + 1;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11;
	logic vld_r1, vld_dv, vld_r2;

	assign en       = !vld_s11 || m_tready;
	assign s_tready = en;

	// Stage 1: unpack and form origin minus centre.
	logic signed [31:0] org_in [3];
	logic signed [31:0] dir_in [3];
	logic signed [31:0] ctr_in [3];

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign org_in[i] = s_tdata[32*i +: 32];
		assign dir_in[i] = s_tdata[96 + 32*i +: 32];
		assign ctr_in[i] = s_tdata[192 + 32*i +: 32];
	end

	logic signed [31:0] org_s1 [3];
	logic signed [31:0] dir_s1 [3];
	logic signed [31:0] d_s1   [3];
	logic [30:0]        rad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				org_s1[i] <= org_in[i];
				dir_s1[i] <= dir_in[i];
				d_s1[i]   <= sat32(64'(org_in[i]) - 64'(ctr_in[i]));
			end
			rad_s1 <= s_tdata[318:288];
		end
	end

	// Stage 2: squares.
	logic signed [31:0] org_s2 [3];
	logic signed [31:0] dir_s2 [3];
	logic signed [31:0] d_s2   [3];
	logic [30:0]        rad_s2;
	logic [63:0]        lsq_s2 [3];
	logic [63:0]        dsq_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				org_s2[i] <= org_s1[i];
				dir_s2[i] <= dir_s1[i];
				d_s2[i]   <= d_s1[i];
				lsq_s2[i] <= 64'(mag32(dir_s1[i])) * 64'(mag32(dir_s1[i]));
				dsq_s2[i] <= 64'(mag32(d_s1[i])) * 64'(mag32(d_s1[i]));
			end
			rad_s2 <= rad_s1;
		end
	end

	// Stage 3: sums of squares.
	logic signed [31:0] org_s3 [3];
	logic signed [31:0] dir_s3 [3];
	logic signed [31:0] d_s3   [3];
	logic [30:0]        rad_s3;
	logic [63:0]        len2_s3;
	logic [63:0]        dd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			org_s3  <= org_s2;
			dir_s3  <= dir_s2;
			d_s3    <= d_s2;
			rad_s3  <= rad_s2;
			len2_s3 <= lsq_s2[0] + lsq_s2[1] + lsq_s2[2];
			dd_s3   <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
		end
	end

	// Direction length.
	logic [SIDE1W-1:0]  side1_in, side1_out;
	logic [31:0]        len_r1;
	logic signed [31:0] org_r1 [3];
	logic signed [31:0] dir_r1 [3];
	logic signed [31:0] d_r1   [3];
	logic [63:0]        dd_r1;
	logic [30:0]        rad_r1;

	assign side1_in = {org_s3[0], org_s3[1], org_s3[2], dir_s3[0], dir_s3[1], dir_s3[2],
		d_s3[0], d_s3[1], d_s3[2], dd_s3, rad_s3};
	assign {org_r1[0], org_r1[1], org_r1[2], dir_r1[0], dir_r1[1], dir_r1[2],
		d_r1[0], d_r1[1], d_r1[2], dd_r1, rad_r1} = side1_out;

	rsi_isqrt #(.IN_W(64), .SIDE_W(SIDE1W)) u_len_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_val   (len2_s3),
		.in_side  (side1_in),
		.out_vld  (vld_r1),
		.out_root (len_r1),
		.out_side (side1_out)
	);

	// Unit direction magnitudes.
	logic [31:0]        num_dv [3];
	logic [QW-1:0]      quo_dv [3];
	logic [SIDE2W-1:0]  side2_in, side2_out;
	logic signed [31:0] org_dv [3];
	logic signed [31:0] d_dv   [3];
	logic [2:0]         neg_dv;
	logic [63:0]        dd_dv;
	logic [30:0]        rad_dv;
	logic               lenz_dv;

	for (genvar i = 0; i < 3; i++) begin : g_num
		assign num_dv[i] = mag32(dir_r1[i]);
	end

	assign side2_in = {org_r1[0], org_r1[1], org_r1[2], dir_r1[0][31], dir_r1[1][31],
		dir_r1[2][31], d_r1[0], d_r1[1], d_r1[2], dd_r1, rad_r1, len_r1 == '0};
	assign {org_dv[0], org_dv[1], org_dv[2], neg_dv[0], neg_dv[1], neg_dv[2],
		d_dv[0], d_dv[1], d_dv[2], dd_dv, rad_dv, lenz_dv} = side2_out;

	rsi_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2W)) u_norm_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_r1),
		.num      (num_dv),
		.den      (len_r1),
		.in_side  (side2_in),
		.out_vld  (vld_dv),
		.quo      (quo_dv),
		.out_side (side2_out)
	);

	// Stage 4: signed unit vector and its products with origin minus centre.
	logic signed [UW-1:0] u_dv [3];

	for (genvar i = 0; i < 3; i++) begin : g_unit
		assign u_dv[i] = lenz_dv   ? '0 :
		                 neg_dv[i] ? -signed'({1'b0, quo_dv[i]}) :
		                             signed'({1'b0, quo_dv[i]});
	end

	logic signed [31:0]    org_s4 [3];
	logic signed [UW-1:0]  u_s4   [3];
	logic signed [UW+31:0] ud_s4  [3];
	logic [63:0]           dd_s4;
	logic [30:0]           rad_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ud_s4[i] <= u_dv[i] * d_dv[i];
			end
			org_s4 <= org_dv;
			u_s4   <= u_dv;
			dd_s4  <= dd_dv;
			rad_s4 <= rad_dv;
		end
	end

	// Stage 5: projection b.
	logic signed [31:0]   org_s5 [3];
	logic signed [UW-1:0] u_s5   [3];
	logic [63:0]          dd_s5;
	logic [30:0]          rad_s5;
	logic signed [31:0]   b_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s5   <= sat32(drop_frac(64'(ud_s4[0]) + 64'(ud_s4[1]) + 64'(ud_s4[2]),
				FRAC_BITS));
			org_s5 <= org_s4;
			u_s5   <= u_s4;
			dd_s5  <= dd_s4;
			rad_s5 <= rad_s4;
		end
	end

	// Stage 6: b squared and radius squared.
	logic signed [31:0]   org_s6 [3];
	logic signed [UW-1:0] u_s6   [3];
	logic [63:0]          dd_s6;
	logic signed [31:0]   b_s6;
	logic [63:0]          bsq_s6;
	logic [61:0]          rsq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s6 <= 64'(mag32(b_s5)) * 64'(mag32(b_s5));
			rsq_s6 <= 62'(rad_s5) * 62'(rad_s5);
			org_s6 <= org_s5;
			u_s6   <= u_s5;
			dd_s6  <= dd_s5;
			b_s6   <= b_s5;
		end
	end

	// Stage 7: positive part of the discriminant.
	logic signed [31:0]   org_s7 [3];
	logic signed [UW-1:0] u_s7   [3];
	logic [63:0]          dd_s7;
	logic signed [31:0]   b_s7;
	logic [63:0]          pos_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s7 <= bsq_s6 + 64'(rsq_s6);
			org_s7 <= org_s6;
			u_s7   <= u_s6;
			dd_s7  <= dd_s6;
			b_s7   <= b_s6;
		end
	end

	// Stage 8: hit test and discriminant.
	logic signed [31:0]   org_s8 [3];
	logic signed [UW-1:0] u_s8   [3];
	logic signed [31:0]   b_s8;
	logic                 hit_s8;
	logic [63:0]          disc_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8  <= pos_s7 >= dd_s7;
			disc_s8 <= (pos_s7 >= dd_s7) ? pos_s7 - dd_s7 : '0;
			org_s8  <= org_s7;
			u_s8    <= u_s7;
			b_s8    <= b_s7;
		end
	end

	// Root of the discriminant.
	logic [SIDE3W-1:0]    side3_in, side3_out;
	logic [31:0]          s_r2;
	logic signed [31:0]   org_r2 [3];
	logic signed [UW-1:0] u_r2   [3];
	logic signed [31:0]   b_r2;
	logic                 hit_r2;

	assign side3_in = {org_s8[0], org_s8[1], org_s8[2], u_s8[0], u_s8[1], u_s8[2],
		b_s8, hit_s8};
	assign {org_r2[0], org_r2[1], org_r2[2], u_r2[0], u_r2[1], u_r2[2],
		b_r2, hit_r2} = side3_out;

	rsi_isqrt #(.IN_W(64), .SIDE_W(SIDE3W)) u_disc_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.in_val   (disc_s8),
		.in_side  (side3_in),
		.out_vld  (vld_r2),
		.out_root (s_r2),
		.out_side (side3_out)
	);

	// Stage 9: choose the root. The nearer root is taken only when it lies
	// ahead of the origin; otherwise the far root is used.
	logic signed [33:0] negb;
	logic signed [33:0] s_ext;
	logic signed [33:0] r_near;
	logic signed [33:0] r_far;
	logic signed [33:0] t_raw;

	always_comb begin
		negb   = -34'(b_r2);
		s_ext  = signed'({2'b00, s_r2});
		r_near = negb - s_ext;
		r_far  = negb + s_ext;
		if (s_r2 == '0) begin
			t_raw = negb;
		end else if (r_near > 34'sd0) begin
			t_raw = r_near;
		end else begin
			t_raw = r_far;
		end
	end

	logic signed [31:0]   org_s9 [3];
	logic signed [UW-1:0] u_s9   [3];
	logic signed [31:0]   t_s9;
	logic                 hit_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9   <= sat32(64'(t_raw));
			org_s9 <= org_r2;
			u_s9   <= u_r2;
			hit_s9 <= hit_r2;
		end
	end

	// Stage 10: distance times unit direction.
	logic signed [31:0]    org_s10 [3];
	logic signed [UW+31:0] tu_s10  [3];
	logic signed [31:0]    t_s10;
	logic                  hit_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tu_s10[i] <= t_s9 * u_s9[i];
			end
			org_s10 <= org_s9;
			t_s10   <= t_s9;
			hit_s10 <= hit_s9;
		end
	end

	// Stage 11: output register; a miss reports zeros.
	logic signed [31:0] pt_s11 [3];
	logic signed [31:0] dist_s11;
	logic               hit_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pt_s11[i] <= hit_s10 ?
					sat32(64'(org_s10[i]) + drop_frac(64'(tu_s10[i]), FRAC_BITS)) : '0;
			end
			dist_s11 <= hit_s10 ? t_s10 : '0;
			hit_s11  <= hit_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_dv;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_r2;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign m_tvalid = vld_s11;
	assign m_tdata  = {pt_s11[2], pt_s11[1], pt_s11[0], dist_s11};
	assign m_tuser  = hit_s11;

endmodule

### rtl/core/rsi_chk.sv
module rsi_chk import rsi_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [RSI_OUT_DATA_W-1:0] m_tdata,
	input logic                      m_tuser
);

	// A result waiting for the receiver holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The input side is blocked only by a stalled result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow the output stall");

	// A miss carries zero distance and zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with non-zero payload");

	// No result can appear straight after reset is released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight after reset");

endmodule

bind ray_sphere_intersect rsi_chk u_rsi_chk (.*);
